>>> hdl/assert_macros.svh
// Assertion helpers for the RTL; connection_aging_table.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/cat_pkg.sv
package cat_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int ID_BITS_DEF  = 16;

  localparam int FUNC_W    = 2;
  localparam int CONN_W    = 16;
  localparam int STATUS_W  = 2;
  localparam int TIMEOUT_W = 16;
  localparam int AGE_W     = 17;
  localparam int OUT_DATA_W = 24;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd30;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_PRESENT   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EVICT
  } state_t;

  typedef enum logic [2:0] {
    CELL_NOP,
    CELL_INSERT,
    CELL_DELETE,
    CELL_AGE,
    CELL_EVICT
  } cell_op_t;

  typedef struct packed {
    cell_op_t               op;
    logic                   wr_ok;
    logic [TIMEOUT_W-1:0]   timeout;
  } cell_cmd_t;

endpackage

>>> hdl/connection_aging_table.sv
// Insert, delete and unused codes: the input is registered on acceptance, EXEC registers
// the result once the output slot is free, and the next input is taken after that.
// Tick: EXEC ages every entry, then EVICT gives one eviction result per cycle while the
// output is not stalled, limited by the one-entry compaction of the cell row per cycle.
// Reset (synchronous): all entries invalid, timeout back to 30.
`include "assert_macros.svh"

module connection_aging_table #(
  parameter int CAPACITY = cat_pkg::CAPACITY_DEF,
  parameter int ID_BITS  = cat_pkg::ID_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [cat_pkg::TIMEOUT_W-1:0]     cfg_wdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [cat_pkg::CONN_W-1:0]        s_tdata,   // conn_id
  input  logic [cat_pkg::FUNC_W-1:0]        s_tuser,   // func
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [cat_pkg::OUT_DATA_W-1:0]    m_tdata,   // status, evicted_id, zero fill
  output logic                              m_tuser,   // evicted_valid
  output logic                              m_tlast
);

  cat_pkg::state_t                 state, state_next;
  logic [cat_pkg::TIMEOUT_W-1:0]   timeout;
  logic [cat_pkg::FUNC_W-1:0]      op_func;
  logic [ID_BITS-1:0]              op_key;

  logic [cat_pkg::STATUS_W-1:0]    out_status, out_status_next;
  logic [cat_pkg::CONN_W-1:0]      out_id, out_id_next;
  logic                            out_evv, out_evv_next;
  logic                            out_last, out_last_next;
  logic                            load;
  logic                            slot_free;

  cat_pkg::cell_cmd_t              cmd;
  logic [CAPACITY-1:0]             valid_vec;
  logic [ID_BITS-1:0]              ids [CAPACITY];
  logic [cat_pkg::AGE_W-1:0]       ages [CAPACITY];
  logic [CAPACITY:0]               chain;
  logic [CAPACITY-1:0]             first_vec;
  logic [CAPACITY-1:0]             more_vec;
  logic                            found;
  logic                            full;
  logic                            more_any;
  logic [ID_BITS-1:0]              ev_id;
  logic                            evict_fire;

  assign chain[0]  = 1'b0;
  assign found     = chain[CAPACITY];
  assign full      = valid_vec[CAPACITY-1];
  assign more_any  = |more_vec;
  assign slot_free = !m_tvalid || m_tready;
  assign s_tready  = (state == cat_pkg::ST_IDLE);

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_row
      logic                      pv;
      logic                      nv;
      logic [ID_BITS-1:0]        nid;
      logic [cat_pkg::AGE_W-1:0] nage;
      if (gi == 0) begin : g_head
        assign pv = 1'b1;
      end else begin : g_body
        assign pv = valid_vec[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_tail
        assign nv   = 1'b0;
        assign nid  = '0;
        assign nage = '0;
      end else begin : g_link
        assign nv   = valid_vec[gi+1];
        assign nid  = ids[gi+1];
        assign nage = ages[gi+1];
      end
      cat_cell #(
        .ID_BITS(ID_BITS)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .cmd       (cmd),
        .key       (op_key),
        .prev_valid(pv),
        .nxt_valid (nv),
        .nxt_id    (nid),
        .nxt_age   (nage),
        .chain_in  (chain[gi]),
        .valid     (valid_vec[gi]),
        .id        (ids[gi]),
        .age       (ages[gi]),
        .chain_out (chain[gi+1]),
        .hit_first (first_vec[gi]),
        .hit_more  (more_vec[gi])
      );
    end
  endgenerate

  // At most one cell flags itself as the first hit, so an OR picks its handle.
  always_comb begin
    ev_id = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      ev_id = ev_id | (first_vec[i] ? ids[i] : '0);
    end
  end

  always_comb begin
    state_next      = state;
    cmd.op          = cat_pkg::CELL_NOP;
    cmd.wr_ok       = !found && !full;
    cmd.timeout     = timeout;
    load            = 1'b0;
    out_status_next = cat_pkg::STATUS_OK;
    out_id_next     = '0;
    out_evv_next    = 1'b0;
    out_last_next   = 1'b1;
    evict_fire      = 1'b0;
    case (state)
      cat_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = cat_pkg::ST_EXEC;
        end
      end
      cat_pkg::ST_EXEC: begin
        if (op_func == cat_pkg::FUNC_TICK) begin
          cmd.op     = cat_pkg::CELL_AGE;
          state_next = cat_pkg::ST_EVICT;
        end else if (slot_free) begin
          load       = 1'b1;
          state_next = cat_pkg::ST_IDLE;
          if (op_func == cat_pkg::FUNC_INSERT) begin
            cmd.op = cat_pkg::CELL_INSERT;
            if (found) begin
              out_status_next = cat_pkg::STATUS_PRESENT;
            end else if (full) begin
              out_status_next = cat_pkg::STATUS_FULL;
            end
          end else if (op_func == cat_pkg::FUNC_DELETE) begin
            cmd.op = cat_pkg::CELL_DELETE;
            if (!found) begin
              out_status_next = cat_pkg::STATUS_NOT_FOUND;
            end
          end
        end
      end
      cat_pkg::ST_EVICT: begin
        if (slot_free) begin
          cmd.op = cat_pkg::CELL_EVICT;
          load   = 1'b1;
          if (chain[CAPACITY]) begin
            evict_fire    = 1'b1;
            out_evv_next  = 1'b1;
            out_id_next   = cat_pkg::CONN_W'(ev_id);
            out_last_next = !more_any;
            if (!more_any) begin
              state_next = cat_pkg::ST_IDLE;
            end
          end else begin
            state_next = cat_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = cat_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= cat_pkg::ST_IDLE;
      timeout  <= cat_pkg::TIMEOUT_RST;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        timeout <= cfg_wdata;
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_func <= s_tuser;
      op_key  <= ID_BITS'(s_tdata);
    end
    if (load) begin
      out_status <= out_status_next;
      out_id     <= out_id_next;
      out_evv    <= out_evv_next;
      out_last   <= out_last_next;
    end
  end

  assign m_tdata = {(cat_pkg::OUT_DATA_W - cat_pkg::CONN_W - cat_pkg::STATUS_W)'(0),
                    out_id, out_status};
  assign m_tuser = out_evv;
  assign m_tlast = out_last;

  `ASSERT_IMP(a_packed, clk, rst, 1'b1,
              (valid_vec & (valid_vec + CAPACITY'(1))) == '0, "table not packed")
  `ASSERT_NXT(a_evict_one, clk, rst, evict_fire,
              $countones(valid_vec) == $past($countones(valid_vec)) - 1,
              "eviction did not drop one entry")
  `ASSERT_IMP(a_more_in_evict, clk, rst, m_tvalid && !m_tlast,
              state == cat_pkg::ST_EVICT, "non-final result outside eviction")

endmodule

>>> hdl/cat_cell.sv
module cat_cell #(
  parameter int ID_BITS = cat_pkg::ID_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cat_pkg::cell_cmd_t        cmd,
  input  logic [ID_BITS-1:0]        key,
  input  logic                      prev_valid,
  input  logic                      nxt_valid,
  input  logic [ID_BITS-1:0]        nxt_id,
  input  logic [cat_pkg::AGE_W-1:0] nxt_age,
  input  logic                      chain_in,
  output logic                      valid,
  output logic [ID_BITS-1:0]        id,
  output logic [cat_pkg::AGE_W-1:0] age,
  output logic                      chain_out,
  output logic                      hit_first,
  output logic                      hit_more
);

  logic                      sel;
  logic [cat_pkg::AGE_W-1:0] limit;
  logic                      take_nxt;
  logic                      put_new;
  logic                      do_age;

  assign limit = {1'b0, cmd.timeout} + cat_pkg::AGE_W'(1);

  always_comb begin
    case (cmd.op)
      cat_pkg::CELL_INSERT, cat_pkg::CELL_DELETE: sel = valid && (id == key);
      cat_pkg::CELL_EVICT: sel = valid && (age > {1'b0, cmd.timeout});
      default: sel = 1'b0;
    endcase
  end

  // On a delete or an eviction, once the selected entry is found, it and every entry
  // after it take the contents of their right neighbor, which keeps the row packed.
  assign chain_out = chain_in | sel;
  assign hit_first = sel & ~chain_in;
  assign hit_more  = sel & chain_in;

  assign take_nxt = ((cmd.op == cat_pkg::CELL_DELETE) || (cmd.op == cat_pkg::CELL_EVICT))
                    && chain_out;
  assign put_new  = (cmd.op == cat_pkg::CELL_INSERT) && cmd.wr_ok && !valid && prev_valid;
  assign do_age   = (cmd.op == cat_pkg::CELL_AGE) && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take_nxt) begin
      valid <= nxt_valid;
    end else if (put_new) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_nxt) begin
      id  <= nxt_id;
      age <= nxt_age;
    end else if (put_new) begin
      id  <= key;
      age <= '0;
    end else if (do_age) begin
      age <= (age >= limit) ? limit : age + cat_pkg::AGE_W'(1);
    end
  end

endmodule

>>> tb/connection_aging_table_test.sv
module connection_aging_table_test;
  import cat_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int CAP          = CAPACITY_DEF;
  localparam int POOL_SIZE    = 24;
  localparam int HOLD_CYCLES  = 200;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                evicted_valid;
    logic [CONN_W-1:0]   evicted_id;
    logic                last;
  } outcome_t;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [CONN_W-1:0]   conn_id;
    logic                typed;
    logic [STATUS_W-1:0] status;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [TIMEOUT_W-1:0]  cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [CONN_W-1:0]     s_tdata = '0;   // conn_id
  logic [FUNC_W-1:0]     s_tuser = '0;   // func
  logic                  m_tvalid;
  logic                  m_tready = 1'b1;
  logic [OUT_DATA_W-1:0] m_tdata;        // status, evicted_id, zero fill
  logic                  m_tuser;        // evicted_valid
  logic                  m_tlast;

  // Shadow of the table in insertion order, plus the shadow timeout.
  logic [CONN_W-1:0]     live_ids[$];
  logic [AGE_W-1:0]      live_ages[$];
  logic [TIMEOUT_W-1:0]  idle_limit = TIMEOUT_RST;
  outcome_t              due[$];

  logic [CONN_W-1:0]     id_pool[POOL_SIZE];
  bit                    quiet = 1'b0;
  bit                    want_hold = 1'b0;
  bit                    hold_done = 1'b0;
  int                    stall_left = 0;
  int                    errors = 0;
  int                    cycles = 0;

  connection_aging_table dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic outcome_t done_only(input logic [STATUS_W-1:0] st);
    return '{st, 1'b0, '0, 1'b1};
  endfunction

  function automatic plan_row_t row(input logic [FUNC_W-1:0] f, input logic [CONN_W-1:0] id,
                                    input logic typed, input logic [STATUS_W-1:0] st);
    return '{f, id, typed, st};
  endfunction

  // Updates the shadow table for one accepted transaction and queues its results.
  function automatic void apply_conn_op(input logic [FUNC_W-1:0] f,
                                        input logic [CONN_W-1:0] id);
    int hit;
    int i;
    int evicted;
    logic [AGE_W-1:0] cap_age;
    hit = -1;
    foreach (live_ids[k]) if (hit < 0 && live_ids[k] == id) hit = k;
    cap_age = {1'b0, idle_limit} + AGE_W'(1);
    evicted = 0;
    case (f)
      FUNC_INSERT: begin
        if (hit >= 0) begin
          due.push_back(done_only(STATUS_PRESENT));
        end else if (live_ids.size() >= CAP) begin
          due.push_back(done_only(STATUS_FULL));
        end else begin
          live_ids.push_back(id);
          live_ages.push_back('0);
          due.push_back(done_only(STATUS_OK));
        end
      end
      FUNC_DELETE: begin
        if (hit < 0) begin
          due.push_back(done_only(STATUS_NOT_FOUND));
        end else begin
          live_ids.delete(hit);
          live_ages.delete(hit);
          due.push_back(done_only(STATUS_OK));
        end
      end
      FUNC_TICK: begin
        foreach (live_ages[k]) begin
          if (live_ages[k] < cap_age) live_ages[k] = live_ages[k] + AGE_W'(1);
          else live_ages[k] = cap_age;
        end
        i = 0;
        while (i < live_ids.size()) begin
          if (live_ages[i] > idle_limit) begin
            due.push_back('{STATUS_OK, 1'b1, live_ids[i], 1'b0});
            live_ids.delete(i);
            live_ages.delete(i);
            evicted++;
          end else begin
            i++;
          end
        end
        if (evicted == 0) due.push_back(done_only(STATUS_OK));
        else due[due.size()-1].last = 1'b1;
      end
      default: begin
        due.push_back(done_only(STATUS_OK));
      end
    endcase
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
    errors++;
  endtask

  task automatic pause_sender();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      s_tdata <= CONN_W'($urandom);
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Holds the item on the input until a transaction takes it.
  task automatic offer(input logic [FUNC_W-1:0] f, input logic [CONN_W-1:0] id);
    bit hit;
    s_tvalid <= 1'b1;
    s_tuser <= f;
    s_tdata <= id;
    do begin
      @(negedge clk);
      hit = (s_tready === 1'b1);
      @(posedge clk);
    end while (!hit);
    apply_conn_op(f, id);
  endtask

  // The timeout is only changed once the block has drained and settled.
  task automatic set_timeout(input logic [TIMEOUT_W-1:0] v);
    s_tvalid <= 1'b0;
    while (due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    idle_limit = v;
  endtask

  // Mostly handles from a small pool, so that hits, misses and a full table all occur.
  task automatic random_run(input int n);
    int r;
    int pick;
    logic [FUNC_W-1:0] f;
    logic [CONN_W-1:0] id;
    for (int j = 0; j < n; j++) begin
      r = $urandom_range(0, 99);
      if (r < 45) f = FUNC_INSERT;
      else if (r < 70) f = FUNC_DELETE;
      else if (r < 95) f = FUNC_TICK;
      else f = FUNC_UNUSED;
      pick = $urandom_range(0, 9);
      if (pick == 7) id = CONN_W'($urandom);
      else if (pick == 8) id = '0;
      else if (pick == 9) id = '1;
      else id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
      pause_sender();
      offer(f, id);
    end
  endtask

  always @(posedge clk) begin
    if (want_hold && !hold_done) begin
      hold_done = 1'b1;
      stall_left = HOLD_CYCLES;
    end else if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 7);
    end
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Outputs are stable between edges, so the transaction is checked at the falling edge before it completes.
  always @(negedge clk) begin
    outcome_t got;
    outcome_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      got = '{m_tdata[STATUS_W-1:0], m_tuser, m_tdata[STATUS_W +: CONN_W], m_tlast};
      if (due.size() == 0) begin
        report("result with nothing due", 32'(got), '0);
      end else begin
        want = due.pop_front();
        if (got.status !== want.status)
          report("status", 32'(got.status), 32'(want.status));
        if (got.evicted_valid !== want.evicted_valid)
          report("evicted_valid", 32'(got.evicted_valid), 32'(want.evicted_valid));
        if (got.evicted_id !== want.evicted_id)
          report("evicted_id", 32'(got.evicted_id), 32'(want.evicted_id));
        if (got.last !== want.last) report("last", 32'(got.last), 32'(want.last));
      end
    end
  end

  initial begin
    plan_row_t plan[$];
    foreach (id_pool[k]) id_pool[k] = CONN_W'($urandom);
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    plan.push_back(row(FUNC_DELETE, 16'h0005, 1'b1, STATUS_NOT_FOUND));
    plan.push_back(row(FUNC_INSERT, 16'h0000, 1'b1, STATUS_OK));
    plan.push_back(row(FUNC_INSERT, 16'h0000, 1'b1, STATUS_PRESENT));
    plan.push_back(row(FUNC_INSERT, 16'hFFFF, 1'b1, STATUS_OK));
    plan.push_back(row(FUNC_UNUSED, 16'hFFFF, 1'b1, STATUS_OK));
    plan.push_back(row(FUNC_TICK, 16'h1234, 1'b1, STATUS_OK));
    plan.push_back(row(FUNC_DELETE, 16'hFFFF, 1'b1, STATUS_OK));
    plan.push_back(row(FUNC_DELETE, 16'hFFFF, 1'b1, STATUS_NOT_FOUND));
    for (int k = 1; k <= 15; k++)
      plan.push_back(row(FUNC_INSERT, 16'(k * 16'h1111), 1'b0, STATUS_OK));
    // The table now holds its full sixteen entries.
    plan.push_back(row(FUNC_INSERT, 16'hABCD, 1'b1, STATUS_FULL));
    plan.push_back(row(FUNC_INSERT, 16'h0000, 1'b1, STATUS_PRESENT));

    foreach (plan[i]) begin
      pause_sender();
      offer(plan[i].func, plan[i].conn_id);
      if (plan[i].typed) begin
        void'(due.pop_back());
        due.push_back(done_only(plan[i].status));
      end
    end

    // Lowering the timeout to zero makes the next tick evict the whole table.
    set_timeout('0);
    offer(FUNC_TICK, 16'h0000);
    offer(FUNC_TICK, 16'hFFFF);

    set_timeout('1);
    want_hold = 1'b1;
    random_run(40);
    set_timeout(16'd3);
    random_run(40);
    set_timeout('0);
    random_run(30);
    set_timeout(16'd1);
    random_run(30);
    set_timeout(16'd6);
    random_run(30);
    quiet = 1'b1;
    set_timeout(16'd2);
    random_run(35);

    s_tvalid <= 1'b0;
    while (due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
